FILE: hdl/cbfm_pkg.sv
// Shared types and codes for the clock buffer frame manager.
// No dependencies; used by every module of the block.
`default_nettype none
package cbfm_pkg;

	typedef enum logic [1:0] {
		FN_READ    = 2'd0,
		FN_UNPIN   = 2'd1,
		FN_ALLOC   = 2'd2,
		FN_DISPOSE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_RESIDENT = 3'd1,
		ST_NOT_PINNED   = 3'd2,
		ST_STILL_PINNED = 3'd3,
		ST_ALL_PINNED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_PIN    = 3'd1,
		CMD_LOAD   = 3'd2,
		CMD_UNPIN  = 3'd3,
		CMD_FREE   = 3'd4,
		CMD_CLRREF = 3'd5
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  file_id;
		logic [31:0] page_no;
		logic        dirty_flag;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  frame;
		logic        hit;
		logic [2:0]  status;
		logic        writeback;
		logic [7:0]  victim_file;
		logic [31:0] victim_page;
		logic        need_fill;
	} out_word_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  file_id;
		logic [31:0] page_no;
		logic        dirty_flag;
	} cell_cmd_t;

	typedef struct packed {
		logic        valid;
		logic        ref_bit;
		logic        pin_zero;
		logic        dirty;
		logic [7:0]  file_id;
		logic [31:0] page_no;
	} cell_state_t;

endpackage
`default_nettype wire

FILE: hdl/clock_buffer_frame_manager_core.sv
// Top level of the clock buffer frame manager: control sequencer and chain of cells.
// Depends on cbfm_pkg and cbfm_cell.
//
// Usage: requests enter on in_valid/in_ready/in_data (func, file_id, page_no,
// dirty_flag); one result word leaves per request on out_valid/out_ready/out_data.
// One request is worked on at a time. The sequencer latches the word in S_IDLE,
// then runs the tag match down the cell chain in S_LOOK; a hit, an unpin or a
// dispose finishes there. A read or allocate miss then runs the clock sweep,
// one frame per cycle, over at most 2*NUM_FRAMES frames; S_PUSH then copies the
// result register to out_data. Sweep length sets how soon the next request is taken.
// in_ready is high only while the sequencer waits for a request.
// Reset clears all valid, pin, reference and dirty bits and parks the hand on
// the last frame; no clearing pass is needed. If the receiver stalls, the
// result word holds on out_data and the next request waits in the sequencer.
`default_nettype none
module clock_buffer_frame_manager_core #(
	parameter int NUM_FRAMES = 16,
	parameter int PIN_BITS   = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire cbfm_pkg::in_word_t in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output cbfm_pkg::out_word_t out_data
);
	localparam int FW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(2 * NUM_FRAMES);

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SWEEP, S_PUSH} state_t;

	state_t               st_q;
	cbfm_pkg::in_word_t   req_q;
	cbfm_pkg::out_word_t  res_q, res_nx;
	logic [FW-1:0]        hand_q, hand_nx;
	logic [CW-1:0]        cnt_q;
	cbfm_pkg::cell_cmd_t  cmd;
	logic [FW-1:0]        tgt;
	logic                 hit_c [NUM_FRAMES+1];
	logic [FW-1:0]        idx_c [NUM_FRAMES+1];
	cbfm_pkg::cell_state_t cs [NUM_FRAMES];
	cbfm_pkg::cell_state_t hs, ms;
	logic                 hit;
	logic [FW-1:0]        hidx;

	assign hit_c[0] = 1'b0;
	assign idx_c[0] = '0;
	assign hit      = hit_c[NUM_FRAMES];
	assign hidx     = idx_c[NUM_FRAMES];
	assign hand_nx  = (hand_q == FW'(NUM_FRAMES - 1)) ? '0 : hand_q + 1'b1;
	assign hs       = cs[hand_nx];
	assign ms       = cs[hidx];
	assign in_ready = st_q == S_IDLE;

	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		cbfm_cell #(.FW(FW), .PIN_BITS(PIN_BITS), .IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.sel    (tgt == FW'(i)),
			.hit_in (hit_c[i]),
			.idx_in (idx_c[i]),
			.hit_out(hit_c[i+1]),
			.idx_out(idx_c[i+1]),
			.state  (cs[i])
		);
	end

	always_comb begin
		cmd.op         = cbfm_pkg::CMD_NONE;
		cmd.file_id    = req_q.file_id;
		cmd.page_no    = req_q.page_no;
		cmd.dirty_flag = req_q.dirty_flag;
		tgt            = hidx;
		case (st_q)
			S_LOOK: begin
				if (hit) begin
					case (cbfm_pkg::func_t'(req_q.func))
						cbfm_pkg::FN_READ, cbfm_pkg::FN_ALLOC: cmd.op = cbfm_pkg::CMD_PIN;
						cbfm_pkg::FN_UNPIN:
							if (!ms.pin_zero) cmd.op = cbfm_pkg::CMD_UNPIN;
						default:
							if (ms.pin_zero) cmd.op = cbfm_pkg::CMD_FREE;
					endcase
				end
			end
			S_SWEEP: begin
				tgt = hand_nx;
				if (!hs.valid || (!hs.ref_bit && hs.pin_zero))
					cmd.op = cbfm_pkg::CMD_LOAD;
				else if (hs.ref_bit)
					cmd.op = cbfm_pkg::CMD_CLRREF;
			end
			default: ;
		endcase
	end

	always_comb begin
		res_nx = res_q;
		case (st_q)
			S_LOOK: begin
				res_nx        = '0;
				res_nx.hit    = hit;
				res_nx.status = cbfm_pkg::ST_ALL_PINNED;
				if (hit) begin
					res_nx.frame  = 4'(hidx);
					res_nx.status = cbfm_pkg::ST_OK;
					if (req_q.func == cbfm_pkg::FN_UNPIN && ms.pin_zero)
						res_nx.status = cbfm_pkg::ST_NOT_PINNED;
					if (req_q.func == cbfm_pkg::FN_DISPOSE && !ms.pin_zero)
						res_nx.status = cbfm_pkg::ST_STILL_PINNED;
				end else if (req_q.func == cbfm_pkg::FN_UNPIN ||
					req_q.func == cbfm_pkg::FN_DISPOSE) begin
					res_nx.status = cbfm_pkg::ST_NOT_RESIDENT;
				end
			end
			S_SWEEP: begin
				if (cmd.op == cbfm_pkg::CMD_LOAD) begin
					res_nx.frame     = 4'(hand_nx);
					res_nx.status    = cbfm_pkg::ST_OK;
					res_nx.need_fill = req_q.func == cbfm_pkg::FN_READ;
					if (hs.valid && hs.dirty) begin
						res_nx.writeback   = 1'b1;
						res_nx.victim_file = hs.file_id;
						res_nx.victim_page = hs.page_no;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			hand_q    <= FW'(NUM_FRAMES - 1);
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == S_PUSH && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid) st_q <= S_LOOK;
				S_LOOK: begin
					cnt_q <= '0;
					if (!hit && (req_q.func == cbfm_pkg::FN_READ ||
						req_q.func == cbfm_pkg::FN_ALLOC))
						st_q <= S_SWEEP;
					else
						st_q <= S_PUSH;
				end
				S_SWEEP: begin
					hand_q <= hand_nx;
					cnt_q  <= cnt_q + 1'b1;
					if (cmd.op == cbfm_pkg::CMD_LOAD || cnt_q == CW'(2 * NUM_FRAMES - 1))
						st_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!out_valid || out_ready)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid)
			req_q <= in_data;
		if (st_q == S_PUSH && (!out_valid || out_ready))
			out_data <= res_q;
		res_q <= res_nx;
	end

	a_all_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == cbfm_pkg::ST_ALL_PINNED |->
		out_data.frame == 4'd0 && !out_data.need_fill && !out_data.hit)
		else $error("all-pinned result carries a frame");
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.need_fill |-> !out_data.hit && out_data.status == cbfm_pkg::ST_OK)
		else $error("fill requested on a hit");
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.writeback |-> !out_data.hit)
		else $error("write-back on a hit");
endmodule
`default_nettype wire

FILE: hdl/cbfm_cell.sv
// One frame of the table: tag, valid, pin count, reference and dirty bits.
// Passes the tag match along the chain. Depends on cbfm_pkg.
`default_nettype none
module cbfm_cell #(
	parameter int FW       = 4,
	parameter int PIN_BITS = 8,
	parameter int IDX      = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire cbfm_pkg::cell_cmd_t cmd,
	input  wire                  sel,
	input  wire                  hit_in,
	input  wire [FW-1:0]         idx_in,
	output logic                 hit_out,
	output logic [FW-1:0]        idx_out,
	output cbfm_pkg::cell_state_t state
);
	logic                valid_q, ref_q, dirty_q;
	logic [PIN_BITS-1:0] pin_q;
	logic [7:0]          file_q;
	logic [31:0]         page_q;
	logic                match;

	assign match   = valid_q && file_q == cmd.file_id && page_q == cmd.page_no;
	assign hit_out = hit_in | match;
	assign idx_out = match ? FW'(IDX) : idx_in;

	assign state.valid    = valid_q;
	assign state.ref_bit  = ref_q;
	assign state.pin_zero = pin_q == '0;
	assign state.dirty    = dirty_q;
	assign state.file_id  = file_q;
	assign state.page_no  = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ref_q   <= 1'b0;
			dirty_q <= 1'b0;
			pin_q   <= '0;
		end else if (sel) begin
			case (cmd.op)
				cbfm_pkg::CMD_PIN: begin
					ref_q <= 1'b1;
					if (!(&pin_q))
						pin_q <= pin_q + 1'b1;
				end
				cbfm_pkg::CMD_LOAD: begin
					valid_q <= 1'b1;
					ref_q   <= 1'b1;
					dirty_q <= 1'b0;
					pin_q   <= PIN_BITS'(1);
				end
				cbfm_pkg::CMD_UNPIN: begin
					pin_q <= pin_q - 1'b1;
					if (cmd.dirty_flag)
						dirty_q <= 1'b1;
				end
				cbfm_pkg::CMD_FREE: begin
					valid_q <= 1'b0;
					ref_q   <= 1'b0;
					dirty_q <= 1'b0;
					pin_q   <= '0;
				end
				cbfm_pkg::CMD_CLRREF: ref_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.op == cbfm_pkg::CMD_LOAD) begin
			file_q <= cmd.file_id;
			page_q <= cmd.page_no;
		end
	end
endmodule
`default_nettype wire
